// File: rtl/core/kdsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kdsg_pkg;

  // Capacities and field widths.
  localparam int MAX_IDS      = 4096;
  localparam int ID_W         = $clog2(MAX_IDS);
  localparam int CNT_W        = ID_W + 1;
  localparam int HASH_SLOTS   = 8192;
  localparam int SLOT_W       = $clog2(HASH_SLOTS);
  localparam int SAMPLE_LIMIT = 65536;
  localparam int SAMP_W       = 16;
  localparam int KEY_W        = 64;
  localparam int OP_W         = 3;
  localparam int POS_W        = 12;
  localparam int ST_W         = 2;
  localparam int REC_W        = SAMP_W + ID_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_KEY     = 3'd0;
  localparam logic [OP_W-1:0] OP_SEG_END = 3'd1;
  localparam logic [OP_W-1:0] OP_FINISH  = 3'd2;
  localparam logic [OP_W-1:0] OP_RD_UNIQ = 3'd3;
  localparam logic [OP_W-1:0] OP_RD_GRP  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_SAMP_OVF = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_POS  = 2'd3;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key_lo;
    logic [KEY_W-1:0]  key_hi;
    logic [POS_W-1:0]  pos;
    logic [SLOT_W-1:0] slot;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [ID_W-1:0]   idx;
    logic              is_new;
    logic [ST_W-1:0]   status;
    logic [KEY_W-1:0]  klo;
    logic [KEY_W-1:0]  khi;
    logic [CNT_W-1:0]  gend;
    logic [SAMP_W-1:0] samp;
    logic [CNT_W-1:0]  ucount;
  } res_t;

  // Home slot of a key: the high word is rotated by half, mixed into the
  // low word, and the result is folded down to the slot width.
  function automatic logic [SLOT_W-1:0] hash_slot(input logic [KEY_W-1:0] lo,
                                                  input logic [KEY_W-1:0] hi);
    logic [KEY_W-1:0]  x;
    logic [KEY_W-1:0]  part;
    logic [SLOT_W-1:0] h;
    x = lo ^ {hi[KEY_W/2-1:0], hi[KEY_W-1:KEY_W/2]};
    h = '0;
    for (int i = 0; i * SLOT_W < KEY_W; i++) begin
      part = x >> (i * SLOT_W);
      h    = h ^ part[SLOT_W-1:0];
    end
    return h;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/kdsg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module kdsg_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_data_i,
  input  wire logic [kdsg_pkg::OP_W-1:0]   opcode_i,
  input  wire logic [kdsg_pkg::KEY_W-1:0]  key_low_i,
  input  wire logic [kdsg_pkg::KEY_W-1:0]  key_high_i,
  input  wire logic [kdsg_pkg::POS_W-1:0]  position_i,
  output kdsg_pkg::item_t                  item_o
);
  import kdsg_pkg::*;

  logic             pair_mode_q;
  logic [KEY_W-1:0] hi_eff;

  // Key layout register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      pair_mode_q <= cfg_data_i;
    end
  end

  // In single-word mode the second word reads as zero.
  assign hi_eff = pair_mode_q ? key_high_i : '0;

  // Classify the item and compute its home slot.
  always_comb begin
    item_o.op     = opcode_i;
    item_o.key_lo = key_low_i;
    item_o.key_hi = hi_eff;
    item_o.pos    = position_i;
    item_o.slot   = hash_slot(key_low_i, hi_eff);
  end

endmodule
`default_nettype wire

// File: rtl/core/kdsg_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module kdsg_fifo (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire kdsg_pkg::item_t data_i,
  output logic         full_o,
  output logic         valid_o,
  input  wire logic    pop_i,
  output kdsg_pkg::item_t data_o
);
  import kdsg_pkg::*;

  item_t      ent_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = ent_q[rd_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/kdsg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module kdsg_back (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    q_valid_i,
  input  wire kdsg_pkg::item_t q_item_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output kdsg_pkg::res_t out_res_o
);
  import kdsg_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CLR     = 5'd1;
  localparam logic [4:0] S_PRB_CHK = 5'd2;
  localparam logic [4:0] S_KEY_CHK = 5'd3;
  localparam logic [4:0] S_RD_U    = 5'd4;
  localparam logic [4:0] S_RD_G    = 5'd5;
  localparam logic [4:0] F_ZERO    = 5'd6;
  localparam logic [4:0] F_CNT_A   = 5'd7;
  localparam logic [4:0] F_CNT_B   = 5'd8;
  localparam logic [4:0] F_CNT_C   = 5'd9;
  localparam logic [4:0] F_PRE_A   = 5'd10;
  localparam logic [4:0] F_PRE_B   = 5'd11;
  localparam logic [4:0] F_SCT_A   = 5'd12;
  localparam logic [4:0] F_SCT_B   = 5'd13;
  localparam logic [4:0] F_SCT_C   = 5'd14;

  // Memories.
  logic [SLOT_W-1:0] slot_mem [HASH_SLOTS];
  logic [KEY_W-1:0]  klo_mem  [MAX_IDS];
  logic [KEY_W-1:0]  khi_mem  [MAX_IDS];
  logic [REC_W-1:0]  rec_mem  [MAX_IDS];
  logic [CNT_W-1:0]  off_mem  [MAX_IDS];
  logic [CNT_W-1:0]  cur_mem  [MAX_IDS];
  logic [SAMP_W-1:0] grp_mem  [MAX_IDS];

  logic [SLOT_W-1:0] slot_raddr, slot_waddr, slot_wdata, slot_rdata;
  logic              slot_we;
  logic [ID_W-1:0]   key_raddr, key_waddr;
  logic [KEY_W-1:0]  key_wlo, key_whi, klo_rdata, khi_rdata;
  logic              key_we;
  logic [ID_W-1:0]   rec_raddr, rec_waddr;
  logic [REC_W-1:0]  rec_wdata, rec_rdata;
  logic              rec_we;
  logic [ID_W-1:0]   off_raddr, off_waddr;
  logic [CNT_W-1:0]  off_wdata, off_rdata;
  logic              off_we;
  logic [ID_W-1:0]   cur_raddr, cur_waddr;
  logic [CNT_W-1:0]  cur_wdata, cur_rdata;
  logic              cur_we;
  logic [ID_W-1:0]   grp_raddr, grp_waddr;
  logic [SAMP_W-1:0] grp_wdata, grp_rdata;
  logic              grp_we;

  // Control state.
  logic [4:0]        state_q, state_d;
  item_t             item_q;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [ID_W-1:0]   cand_q, cand_d;
  logic [CNT_W-1:0]  id_cnt_q, id_cnt_d;
  logic [CNT_W-1:0]  dist_q, dist_d;
  logic [SAMP_W-1:0] samp_q, samp_d;
  logic [CNT_W-1:0]  fin_q, fin_d;
  logic [CNT_W-1:0]  u_q, u_d;
  logic [CNT_W-1:0]  r_q, r_d;
  logic [CNT_W-1:0]  run_q, run_d;
  logic [ID_W-1:0]   uidx_q, uidx_d;
  logic [SAMP_W-1:0] smp_q, smp_d;
  logic [SLOT_W-1:0] clr_q, clr_d;
  logic              out_valid_q;
  res_t              res_q, res;
  logic              emit;

  logic [CNT_W-1:0]  r_m1;
  logic [CNT_W-1:0]  run_sum;
  logic [CNT_W-1:0]  cur_m1;
  logic [ID_W-1:0]   slot_id;
  logic              key_hit;

  assign r_m1    = r_q - CNT_W'(1);
  assign run_sum = run_q + off_rdata;
  assign cur_m1  = cur_rdata - CNT_W'(1);
  assign slot_id = ID_W'(slot_rdata - SLOT_W'(1));
  assign key_hit = (klo_rdata == item_q.key_lo) && (khi_rdata == item_q.key_hi);

  // Sequencer for all operations.
  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    cand_d     = cand_q;
    id_cnt_d   = id_cnt_q;
    dist_d     = dist_q;
    samp_d     = samp_q;
    fin_d      = fin_q;
    u_d        = u_q;
    r_d        = r_q;
    run_d      = run_q;
    uidx_d     = uidx_q;
    smp_d      = smp_q;
    clr_d      = clr_q;
    q_pop_o    = 1'b0;
    emit       = 1'b0;
    res        = '0;
    slot_raddr = slot_q;
    slot_we    = 1'b0;
    slot_waddr = slot_q;
    slot_wdata = '0;
    key_raddr  = cand_q;
    key_we     = 1'b0;
    key_waddr  = dist_q[ID_W-1:0];
    key_wlo    = item_q.key_lo;
    key_whi    = item_q.key_hi;
    rec_raddr  = r_q[ID_W-1:0];
    rec_we     = 1'b0;
    rec_waddr  = id_cnt_q[ID_W-1:0];
    rec_wdata  = '0;
    off_raddr  = u_q[ID_W-1:0];
    off_we     = 1'b0;
    off_waddr  = u_q[ID_W-1:0];
    off_wdata  = '0;
    cur_raddr  = uidx_q;
    cur_we     = 1'b0;
    cur_waddr  = uidx_q;
    cur_wdata  = '0;
    grp_raddr  = item_q.pos;
    grp_we     = 1'b0;
    grp_waddr  = cur_m1[ID_W-1:0];
    grp_wdata  = smp_q;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && !out_valid_q) begin
          q_pop_o = 1'b1;
          unique case (q_item_i.op)
            OP_KEY: begin
              if (id_cnt_q >= CNT_W'(MAX_IDS)) begin
                emit       = 1'b1;
                res.status = ST_FULL;
              end else begin
                slot_raddr = q_item_i.slot;
                slot_d     = q_item_i.slot;
                state_d    = S_PRB_CHK;
              end
            end
            OP_SEG_END: begin
              emit = 1'b1;
              if ({1'b0, samp_q} + (SAMP_W+1)'(1) >= (SAMP_W+1)'(SAMPLE_LIMIT)) begin
                res.status = ST_SAMP_OVF;
              end else begin
                samp_d = samp_q + SAMP_W'(1);
              end
            end
            OP_FINISH: begin
              u_d     = '0;
              state_d = F_ZERO;
            end
            OP_RD_UNIQ: begin
              if ({1'b0, q_item_i.pos} >= dist_q) begin
                emit       = 1'b1;
                res.status = ST_BAD_POS;
              end else begin
                key_raddr = q_item_i.pos;
                off_raddr = q_item_i.pos;
                state_d   = S_RD_U;
              end
            end
            OP_RD_GRP: begin
              if ({1'b0, q_item_i.pos} >= id_cnt_q) begin
                emit       = 1'b1;
                res.status = ST_BAD_POS;
              end else begin
                grp_raddr = q_item_i.pos;
                state_d   = S_RD_G;
              end
            end
            OP_CLEAR: begin
              emit     = 1'b1;
              id_cnt_d = '0;
              dist_d   = '0;
              samp_d   = '0;
              fin_d    = '0;
              clr_d    = '0;
              state_d  = S_CLR;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_CLR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        clr_d      = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(HASH_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_PRB_CHK: begin
        if (slot_rdata == '0) begin
          emit = 1'b1;
          if (dist_q >= CNT_W'(MAX_IDS)) begin
            res.status = ST_FULL;
          end else begin
            slot_we    = 1'b1;
            slot_wdata = SLOT_W'(dist_q + CNT_W'(1));
            key_we     = 1'b1;
            rec_we     = 1'b1;
            rec_wdata  = {samp_q, dist_q[ID_W-1:0]};
            id_cnt_d   = id_cnt_q + CNT_W'(1);
            dist_d     = dist_q + CNT_W'(1);
            res.idx    = dist_q[ID_W-1:0];
            res.is_new = 1'b1;
          end
          state_d = S_IDLE;
        end else begin
          key_raddr = slot_id;
          cand_d    = slot_id;
          state_d   = S_KEY_CHK;
        end
      end
      S_KEY_CHK: begin
        if (key_hit) begin
          emit      = 1'b1;
          rec_we    = 1'b1;
          rec_wdata = {samp_q, cand_q};
          id_cnt_d  = id_cnt_q + CNT_W'(1);
          res.idx   = cand_q;
          state_d   = S_IDLE;
        end else begin
          // Linear probing: the slot index wraps at the table size.
          slot_d     = slot_q + SLOT_W'(1);
          slot_raddr = slot_q + SLOT_W'(1);
          state_d    = S_PRB_CHK;
        end
      end
      S_RD_U: begin
        emit     = 1'b1;
        res.idx  = item_q.pos;
        res.klo  = klo_rdata;
        res.khi  = khi_rdata;
        // Offsets beyond the last finish read as zero.
        res.gend = ({1'b0, item_q.pos} < fin_q) ? off_rdata : '0;
        state_d  = S_IDLE;
      end
      S_RD_G: begin
        emit     = 1'b1;
        res.samp = grp_rdata;
        state_d  = S_IDLE;
      end
      F_ZERO: begin
        if (u_q < dist_q) begin
          off_we = 1'b1;
          u_d    = u_q + CNT_W'(1);
        end else begin
          r_d     = '0;
          state_d = F_CNT_A;
        end
      end
      F_CNT_A: begin
        if (r_q < id_cnt_q) begin
          rec_raddr = r_q[ID_W-1:0];
          state_d   = F_CNT_B;
        end else begin
          u_d     = '0;
          run_d   = '0;
          state_d = F_PRE_A;
        end
      end
      F_CNT_B: begin
        off_raddr = rec_rdata[ID_W-1:0];
        uidx_d    = rec_rdata[ID_W-1:0];
        state_d   = F_CNT_C;
      end
      F_CNT_C: begin
        off_we    = 1'b1;
        off_waddr = uidx_q;
        off_wdata = off_rdata + CNT_W'(1);
        r_d       = r_q + CNT_W'(1);
        state_d   = F_CNT_A;
      end
      F_PRE_A: begin
        if (u_q < dist_q) begin
          off_raddr = u_q[ID_W-1:0];
          state_d   = F_PRE_B;
        end else begin
          r_d     = id_cnt_q;
          state_d = F_SCT_A;
        end
      end
      F_PRE_B: begin
        off_we    = 1'b1;
        off_wdata = run_sum;
        cur_we    = 1'b1;
        cur_waddr = u_q[ID_W-1:0];
        cur_wdata = run_sum;
        run_d     = run_sum;
        u_d       = u_q + CNT_W'(1);
        state_d   = F_PRE_A;
      end
      F_SCT_A: begin
        if (r_q != '0) begin
          rec_raddr = r_m1[ID_W-1:0];
          state_d   = F_SCT_B;
        end else begin
          emit    = 1'b1;
          fin_d   = dist_q;
          state_d = S_IDLE;
        end
      end
      F_SCT_B: begin
        cur_raddr = rec_rdata[ID_W-1:0];
        uidx_d    = rec_rdata[ID_W-1:0];
        smp_d     = rec_rdata[REC_W-1:ID_W];
        state_d   = F_SCT_C;
      end
      F_SCT_C: begin
        // Fill each group from its end, walking the records backward.
        if (cur_rdata != '0) begin
          cur_we    = 1'b1;
          cur_wdata = cur_m1;
          grp_we    = 1'b1;
        end
        r_d     = r_m1;
        state_d = F_SCT_A;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    res.ucount = dist_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      id_cnt_q    <= '0;
      dist_q      <= '0;
      samp_q      <= '0;
      fin_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      id_cnt_q <= id_cnt_d;
      dist_q   <= dist_d;
      samp_q   <= samp_d;
      fin_q    <= fin_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
    slot_q <= slot_d;
    cand_q <= cand_d;
    u_q    <= u_d;
    r_q    <= r_d;
    run_q  <= run_d;
    uidx_q <= uidx_d;
    smp_q  <= smp_d;
    if (emit) begin
      res_q <= res;
    end
  end

  // Hash slot table.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata <= slot_mem[slot_raddr];
  end

  // Unique key store.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      klo_mem[key_waddr] <= key_wlo;
      khi_mem[key_waddr] <= key_whi;
    end
    klo_rdata <= klo_mem[key_raddr];
    khi_rdata <= khi_mem[key_raddr];
  end

  // Occurrence records.
  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    rec_rdata <= rec_mem[rec_raddr];
  end

  // Group counts, then cumulative group ends.
  always_ff @(posedge clk_i) begin
    if (off_we) begin
      off_mem[off_waddr] <= off_wdata;
    end
    off_rdata <= off_mem[off_raddr];
  end

  // Fill cursors for the scatter pass.
  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[cur_waddr] <= cur_wdata;
    end
    cur_rdata <= cur_mem[cur_raddr];
  end

  // Grouped sample list.
  always_ff @(posedge clk_i) begin
    if (grp_we) begin
      grp_mem[grp_waddr] <= grp_wdata;
    end
    grp_rdata <= grp_mem[grp_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule
`default_nettype wire

// File: rtl/core/key_dedup_with_sample_grouping.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Transfer when            Payload
// input     in         in_valid_i & !in_stall_o  opcode, key_low, key_high, position
// output    out        out_valid_o & !out_stall_i unique_index .. unique_count
// config    in         cfg_we_i                  cfg_data_i (pair_mode)
//
// A two-entry queue separates the classifying front from the back engine.
// A key reads its home slot, then compares the stored key and probes the next
// slot while another key holds it; finish counts occurrences per distinct key,
// forms cumulative group ends and scatters the sample numbers into the groups.
// The back takes the next item only once the previous result has left.
// After reset and after a clear, a sweep empties the hash table before the
// next item is started. A stalled result blocks the back; the input stalls
// only once the queue between front and back is full.
module key_dedup_with_sample_grouping (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic                               cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [kdsg_pkg::OP_W-1:0]          opcode_i,
  input  wire logic signed [kdsg_pkg::KEY_W-1:0]  key_low_i,
  input  wire logic signed [kdsg_pkg::KEY_W-1:0]  key_high_i,
  input  wire logic [kdsg_pkg::POS_W-1:0]         position_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [kdsg_pkg::ID_W-1:0]               unique_index_o,
  output logic                                    is_new_o,
  output logic [kdsg_pkg::ST_W-1:0]               status_o,
  output logic signed [kdsg_pkg::KEY_W-1:0]       unique_key_low_o,
  output logic signed [kdsg_pkg::KEY_W-1:0]       unique_key_high_o,
  output logic [kdsg_pkg::CNT_W-1:0]              group_end_o,
  output logic [kdsg_pkg::SAMP_W-1:0]             sample_number_o,
  output logic [kdsg_pkg::CNT_W-1:0]              unique_count_o
);
  import kdsg_pkg::*;

  item_t front_item;
  item_t q_item;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  logic  push;
  res_t  res;

  // Front: classification and hashing.
  kdsg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .opcode_i   (opcode_i),
    .key_low_i  (key_low_i),
    .key_high_i (key_high_i),
    .position_i (position_i),
    .item_o     (front_item)
  );

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  // Queue between front and back.
  kdsg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_item)
  );

  // Back: table engine and result register.
  kdsg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (res)
  );

  // Result fields.
  assign unique_index_o    = res.idx;
  assign is_new_o          = res.is_new;
  assign status_o          = res.status;
  assign unique_key_low_o  = res.klo;
  assign unique_key_high_o = res.khi;
  assign group_end_o       = res.gend;
  assign sample_number_o   = res.samp;
  assign unique_count_o    = res.ucount;

endmodule
`default_nettype wire
